// ===== src/timestamp_delta_histogram_macros.svh =====
// ============================================================================
// Assertion macros for timestamp_delta_histogram
// Immediate-implication and next-cycle assertion helpers, empty in synthesis.
// ============================================================================
`ifndef TIMESTAMP_DELTA_HISTOGRAM_MACROS_SVH
`define TIMESTAMP_DELTA_HISTOGRAM_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define TDH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled during reset
`define TDH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TDH_ASSERT_NOW(lbl, ante, cons, msg)
`define TDH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/tdh_pkg.sv =====
// ============================================================================
// tdh_pkg
// Shared constants and helpers for the timestamp delta histogram.
// ============================================================================
package tdh_pkg;

    // default histogram geometry
    localparam int DEF_BIN_WIDTH = 128;
    localparam int DEF_NUM_BINS  = 16;

    // start values of the running extremes
    localparam logic [31:0] MIN_START = 32'h7fff_ffff;
    localparam logic [31:0] MAX_START = 32'h8000_0001;

    // counter value at which a bin stops counting
    localparam logic [31:0] CNT_FULL = 32'hffff_ffff;

    // saturating increment of a bin counter
    function automatic logic [31:0] sat_inc(input logic [31:0] value);
        logic [31:0] result;
        if (value == CNT_FULL)
        begin
            result = value;
        end
        else
        begin
            result = value + 32'd1;
        end
        return result;
    endfunction

endpackage

// ===== src/timestamp_delta_histogram.sv =====
// ============================================================================
// timestamp_delta_histogram
// Per-packet timestamp delta, running min/max and saturating delta histogram.
// ============================================================================
// One media timestamp is taken per transfer and one result comes out per
// transfer, in order. The block accepts a new timestamp every cycle while the
// result channel does not stall; each goes through the input stage, subtract,
// reciprocal multiply, divide correction with the counter read, and counter
// update into the output register. The rate is set by the bin counter
// memory, which is read once and written once per cycle, with forwarding
// between neighboring items. Bin counters are cleared at reset by per-bin
// valid bits, so there is no clearing pass. The first timestamp after reset
// gives a result with delta_valid low and zero delta, bin and count.
// ============================================================================
`include "timestamp_delta_histogram_macros.svh"

module timestamp_delta_histogram
    import tdh_pkg::*;
#(
    parameter int BIN_WIDTH = DEF_BIN_WIDTH,
    parameter int NUM_BINS  = DEF_NUM_BINS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        media_timestamp,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               delta_valid,
    output logic signed [31:0] delta,
    output logic [7:0]         bin_index,
    output logic [31:0]        bin_count,
    output logic signed [31:0] delta_min,
    output logic signed [31:0] delta_max
);

    // ------------------------------------------------------------------
    // derived geometry
    // ------------------------------------------------------------------
    localparam int BIN_W     = $clog2(NUM_BINS);
    // deltas at or above this land in the last bin
    localparam int CAP_LIMIT = (NUM_BINS - 2) * BIN_WIDTH;
    localparam int DN_W      = (CAP_LIMIT > 1) ? $clog2(CAP_LIMIT) : 1;
    localparam int RECIP_W   = DN_W + 1;
    localparam int PROD_W    = DN_W + RECIP_W + BIN_W;
    // floor(2^DN_W / BIN_WIDTH): quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((longint'(1) << DN_W) / BIN_WIDTH);
    localparam logic [DN_W:0]      BW_C      = (DN_W + 1)'(BIN_WIDTH);
    localparam logic [31:0]        CAP_C     = 32'(CAP_LIMIT);
    localparam logic [BIN_W-1:0]   LAST_BIN  = BIN_W'(NUM_BINS - 1);

    // ------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------
    logic              a_v_reg, b_v_reg, c_v_reg, d_v_reg, o_v_reg;
    logic              a_v_next, b_v_next, c_v_next, d_v_next, o_v_next;

    logic [31:0]       last_ts_reg;
    logic              have_prev_reg;
    logic [31:0]       run_min_reg, run_min_next;
    logic [31:0]       run_max_reg, run_max_next;

    logic [31:0]       a_ts_reg, a_prev_reg;
    logic              a_first_reg;

    logic [31:0]       b_delta_reg;
    logic              b_first_reg;

    logic [31:0]       c_delta_reg, c_min_reg, c_max_reg;
    logic              c_first_reg, c_neg_reg, c_cap_reg;
    logic [DN_W-1:0]   c_dn_reg;
    logic [BIN_W-1:0]  c_qest_reg;

    logic [31:0]       d_delta_reg, d_min_reg, d_max_reg;
    logic              d_first_reg;
    logic [BIN_W-1:0]  d_bin_reg;
    logic              d_rdvld_reg, d_fwd_reg;
    logic [31:0]       d_fwd_cnt_reg;
    logic [31:0]       rd_data_reg;

    logic              o_dvalid_reg;
    logic [31:0]       o_delta_reg, o_count_reg, o_min_reg, o_max_reg;
    logic [7:0]        o_bin_reg;

    // bin counter memory and its per-bin valid bits
    logic [31:0]       cnt_mem [NUM_BINS];
    logic [NUM_BINS-1:0] mem_vld_reg, mem_vld_next;

    // ------------------------------------------------------------------
    // stage flow control
    // ------------------------------------------------------------------
    logic o_free, d_free, c_free, b_free, a_free;
    logic d_adv, c_adv, b_adv, a_adv, in_xfer;

    assign o_free  = !o_v_reg || out_ready;
    assign d_adv   = d_v_reg && o_free;
    assign d_free  = !d_v_reg || o_free;
    assign c_adv   = c_v_reg && d_free;
    assign c_free  = !c_v_reg || d_free;
    assign b_adv   = b_v_reg && c_free;
    assign b_free  = !b_v_reg || c_free;
    assign a_adv   = a_v_reg && b_free;
    assign a_free  = !a_v_reg || b_free;
    assign in_ready = a_free;
    assign in_xfer  = in_valid && a_free;

    always_comb
    begin
        a_v_next = in_xfer ? 1'b1 : (a_adv ? 1'b0 : a_v_reg);
        b_v_next = a_adv   ? 1'b1 : (b_adv ? 1'b0 : b_v_reg);
        c_v_next = b_adv   ? 1'b1 : (c_adv ? 1'b0 : c_v_reg);
        d_v_next = c_adv   ? 1'b1 : (d_adv ? 1'b0 : d_v_reg);
        o_v_next = d_adv   ? 1'b1 : ((o_v_reg && out_ready) ? 1'b0 : o_v_reg);
    end

    // ------------------------------------------------------------------
    // running min / max, updated as an item leaves stage B
    // ------------------------------------------------------------------
    always_comb
    begin
        run_min_next = run_min_reg;
        run_max_next = run_max_reg;
        if (!b_first_reg)
        begin
            if ($signed(b_delta_reg) < $signed(run_min_reg))
            begin
                run_min_next = b_delta_reg;
            end
            if ($signed(b_delta_reg) > $signed(run_max_reg))
            begin
                run_max_next = b_delta_reg;
            end
        end
    end

    // quotient estimate: delta times reciprocal
    logic [PROD_W-1:0] qprod;
    logic [BIN_W-1:0]  b_qest;
    assign qprod  = PROD_W'(b_delta_reg[DN_W-1:0]) * PROD_W'(RECIP);
    assign b_qest = qprod[DN_W +: BIN_W];

    // quotient correction and final bin
    logic [DN_W:0]    qmul;
    logic [DN_W:0]    qrem;
    logic [BIN_W-1:0] c_quot;
    logic [BIN_W-1:0] c_bin;
    assign qmul   = (DN_W + 1)'(c_qest_reg) * BW_C;
    assign qrem   = {1'b0, c_dn_reg} - qmul;
    assign c_quot = c_qest_reg + BIN_W'(qrem >= BW_C);

    always_comb
    begin
        if (c_neg_reg)
        begin
            c_bin = '0;
        end
        else if (c_cap_reg)
        begin
            c_bin = LAST_BIN;
        end
        else
        begin
            c_bin = c_quot + BIN_W'(1);
        end
    end

    // counter read-modify-write with forwarding from the item ahead
    logic [31:0] d_cnt_old;
    logic [31:0] cnt_new;
    logic        mem_we;
    logic        fwd_hit;
    assign d_cnt_old = d_fwd_reg ? d_fwd_cnt_reg : (d_rdvld_reg ? rd_data_reg : 32'd0);
    assign cnt_new   = sat_inc(d_cnt_old);
    assign mem_we    = d_adv && !d_first_reg;
    assign fwd_hit   = mem_we && (c_bin == d_bin_reg);

    always_comb
    begin
        mem_vld_next = mem_vld_reg;
        if (mem_we)
        begin
            mem_vld_next[d_bin_reg] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            d_v_reg       <= 1'b0;
            o_v_reg       <= 1'b0;
            last_ts_reg   <= '0;
            have_prev_reg <= 1'b0;
            run_min_reg   <= MIN_START;
            run_max_reg   <= MAX_START;
            mem_vld_reg   <= '0;
        end
        else
        begin
            a_v_reg     <= a_v_next;
            b_v_reg     <= b_v_next;
            c_v_reg     <= c_v_next;
            d_v_reg     <= d_v_next;
            o_v_reg     <= o_v_next;
            mem_vld_reg <= mem_vld_next;
            if (in_xfer)
            begin
                last_ts_reg   <= media_timestamp;
                have_prev_reg <= 1'b1;
            end
            if (b_adv)
            begin
                run_min_reg <= run_min_next;
                run_max_reg <= run_max_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload stages
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_ts_reg    <= media_timestamp;
            a_prev_reg  <= last_ts_reg;
            a_first_reg <= !have_prev_reg;
        end
        if (a_adv)
        begin
            b_delta_reg <= a_ts_reg - a_prev_reg;
            b_first_reg <= a_first_reg;
        end
        if (b_adv)
        begin
            c_delta_reg <= b_delta_reg;
            c_first_reg <= b_first_reg;
            c_min_reg   <= run_min_next;
            c_max_reg   <= run_max_next;
            c_neg_reg   <= b_delta_reg[31];
            c_cap_reg   <= b_delta_reg >= CAP_C;
            c_dn_reg    <= b_delta_reg[DN_W-1:0];
            c_qest_reg  <= b_qest;
        end
        if (c_adv)
        begin
            d_delta_reg   <= c_delta_reg;
            d_first_reg   <= c_first_reg;
            d_min_reg     <= c_min_reg;
            d_max_reg     <= c_max_reg;
            d_bin_reg     <= c_bin;
            d_rdvld_reg   <= mem_vld_reg[c_bin];
            d_fwd_reg     <= fwd_hit;
            d_fwd_cnt_reg <= cnt_new;
        end
        if (d_adv)
        begin
            o_dvalid_reg <= !d_first_reg;
            o_delta_reg  <= d_first_reg ? 32'd0 : d_delta_reg;
            o_bin_reg    <= d_first_reg ? 8'd0 : 8'(d_bin_reg);
            o_count_reg  <= d_first_reg ? 32'd0 : cnt_new;
            o_min_reg    <= d_min_reg;
            o_max_reg    <= d_max_reg;
        end
    end

    // counter memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[d_bin_reg] <= cnt_new;
        end
        if (c_adv)
        begin
            rd_data_reg <= cnt_mem[c_bin];
        end
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign out_valid   = o_v_reg;
    assign delta_valid = o_dvalid_reg;
    assign delta       = $signed(o_delta_reg);
    assign bin_index   = o_bin_reg;
    assign bin_count   = o_count_reg;
    assign delta_min   = $signed(o_min_reg);
    assign delta_max   = $signed(o_max_reg);

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a result transfer that carries a binned delta
    logic res_binned;
    assign res_binned = out_valid && delta_valid;

    `TDH_ASSERT_NOW(a_min_le_delta, res_binned, delta_min <= delta, "delta_min above delta")
    `TDH_ASSERT_NOW(a_neg_bin_zero, res_binned && delta[31], bin_index == 8'd0, "bin not 0")
    `TDH_ASSERT_NOW(a_count_nonzero, res_binned, bin_count != 32'd0, "zero count")
    `TDH_ASSERT_NEXT(a_bin_marked, mem_we, mem_vld_reg[$past(d_bin_reg)], "bin not marked")

endmodule

// ===== test/timestamp_delta_histogram_tb.sv =====
// ============================================================================
// timestamp_delta_histogram_tb
// Self-checking bench: timestamps go in over a valid/ready channel, and every
// result is checked against its typed table entry or a model of the delta,
// the min/max tracking and the saturating histogram. A directed table comes
// first, then about a thousand random timestamps, mostly steady packet streams
// with jitter and wraps. Both channels idle in random bursts, none at the end.
// ============================================================================
module timestamp_delta_histogram_tb;
    import tdh_pkg::*;

    localparam int BIN_W          = DEF_BIN_WIDTH;
    localparam int NBINS          = DEF_NUM_BINS;
    localparam int DIRECTED_ROWS  = 17;
    localparam int RANDOM_ITEMS   = 1035;
    localparam int TAIL_ITEMS     = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic               flag;
        logic signed [31:0] dval;
        logic [7:0]         bin;
        logic [31:0]        count;
        logic signed [31:0] dmin;
        logic signed [31:0] dmax;
    } delta_result_t;

    typedef struct packed {
        logic [31:0]   stamp;
        logic          typed;
        delta_result_t res;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        media_timestamp;
    logic               out_valid;
    logic               out_ready;
    logic               delta_valid;
    logic signed [31:0] delta;
    logic [7:0]         bin_index;
    logic [31:0]        bin_count;
    logic signed [31:0] delta_min;
    logic signed [31:0] delta_max;

    // local copy of the block state
    logic [31:0]        prev_stamp;
    logic               stamp_seen;
    logic signed [31:0] low_water;
    logic signed [31:0] high_water;
    logic [31:0]        bin_tally [NBINS];

    delta_result_t pending_results [$];
    int            fail_count;
    bit            tail_phase;
    int            gap_pct;

    // directed cases; typed results only where they are obvious
    stim_row_t directed_stim [DIRECTED_ROWS] = '{
        // first packet after reset: nothing binned, start extremes
        '{32'h0000_0000, 1'b1, '{1'b0, 32'h0, 8'd0, 32'd0, MIN_START, MAX_START}},
        // most negative delta lowers min, max stays at its start value
        '{32'h8000_0000, 1'b1,
          '{1'b1, 32'h8000_0000, 8'd0, 32'd1, 32'h8000_0000, MAX_START}},
        // delta equal to the max start value does not raise it
        '{32'h0000_0001, 1'b1,
          '{1'b1, 32'h8000_0001, 8'd0, 32'd2, 32'h8000_0000, MAX_START}},
        // zero delta
        '{32'h0000_0001, 1'b1, '{1'b1, 32'h0, 8'd1, 32'd1, 32'h8000_0000, 32'h0}},
        // last delta of bin 1, first of bin 2
        '{32'h0000_0080, 1'b1, '{1'b1, 32'h7f, 8'd1, 32'd2, 32'h8000_0000, 32'h7f}},
        '{32'h0000_0100, 1'b1, '{1'b1, 32'h80, 8'd2, 32'd1, 32'h8000_0000, 32'h80}},
        // top bin reached exactly, then capped, then the bin below
        '{32'h0000_087f, 1'b1,
          '{1'b1, 32'h77f, 8'd15, 32'd1, 32'h8000_0000, 32'h77f}},
        '{32'h0000_0fff, 1'b1,
          '{1'b1, 32'h780, 8'd15, 32'd2, 32'h8000_0000, 32'h780}},
        '{32'h0000_16fe, 1'b1,
          '{1'b1, 32'h6ff, 8'd14, 32'd1, 32'h8000_0000, 32'h780}},
        // largest positive delta
        '{32'h8000_16fd, 1'b1,
          '{1'b1, 32'h7fff_ffff, 8'd15, 32'd3, 32'h8000_0000, 32'h7fff_ffff}},
        '{32'hffff_ffff, 1'b0, '0},
        // wrap through zero
        '{32'h0000_0000, 1'b0, '0},
        '{32'hffff_fff0, 1'b0, '0},
        '{32'h5a5a_5a5a, 1'b0, '0},
        '{32'ha5a5_a5a5, 1'b0, '0},
        '{32'hffff_ffff, 1'b0, '0},
        '{32'h0000_0000, 1'b0, '0}
    };

    timestamp_delta_histogram #(
        .BIN_WIDTH (BIN_W),
        .NUM_BINS  (NBINS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .media_timestamp (media_timestamp),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .delta_valid     (delta_valid),
        .delta           (delta),
        .bin_index       (bin_index),
        .bin_count       (bin_count),
        .delta_min       (delta_min),
        .delta_max       (delta_max)
    );

    // 10-unit clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // delta, extremes and histogram update for one accepted timestamp
    task automatic predict_delta(input logic [31:0] stamp, output delta_result_t r);
        logic signed [31:0] diff;
        int                 slot;
        r = '0;
        if (stamp_seen)
        begin
            diff = stamp - prev_stamp;
            if (diff < low_water)
            begin
                low_water = diff;
            end
            if (diff > high_water)
            begin
                high_water = diff;
            end
            if (diff < 0)
            begin
                slot = 0;
            end
            else
            begin
                slot = 1 + int'(diff / BIN_W);
                if (slot >= NBINS)
                begin
                    slot = NBINS - 1;
                end
            end
            if (bin_tally[slot] != CNT_FULL)
            begin
                bin_tally[slot] = bin_tally[slot] + 32'd1;
            end
            r.flag  = 1'b1;
            r.dval  = diff;
            r.bin   = 8'(slot);
            r.count = bin_tally[slot];
        end
        r.dmin     = low_water;
        r.dmax     = high_water;
        prev_stamp = stamp;
        stamp_seen = 1'b1;
    endtask

    // one timestamp transfer, with an optional idle burst in front
    task automatic send_stamp(input logic [31:0] stamp, input logic use_given,
                              input delta_result_t given);
        delta_result_t predicted;
        if (!tail_phase && gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        media_timestamp <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        predict_delta(stamp, predicted);
        pending_results.push_back(use_given ? given : predicted);
    endtask

    // compare one result transfer with the oldest prediction
    task automatic check_result();
        delta_result_t seen;
        delta_result_t want;
        seen = '{delta_valid, delta, bin_index, bin_count, delta_min, delta_max};
        if (pending_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
            begin
                $display("unexpected result: valid=%0b delta=%h bin=%0d count=%0d min=%h max=%h",
                         seen.flag, seen.dval, seen.bin, seen.count, seen.dmin, seen.dmax);
            end
        end
        else
        begin
            want = pending_results.pop_front();
            if (seen.flag !== want.flag || seen.dval !== want.dval ||
                seen.bin !== want.bin || seen.count !== want.count ||
                seen.dmin !== want.dmin || seen.dmax !== want.dmax)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("mismatch exp: valid=%0b delta=%h bin=%0d count=%0d min=%h max=%h",
                             want.flag, want.dval, want.bin, want.count, want.dmin, want.dmax);
                    $display("         got: valid=%0b delta=%h bin=%0d count=%0d min=%h max=%h",
                             seen.flag, seen.dval, seen.bin, seen.count, seen.dmin, seen.dmax);
                end
            end
        end
    endtask

    // result side: check transfers, stall in random bursts
    initial
    begin : result_sink
        int stall_left;
        int stall_pct;
        int cycle_no;
        out_ready  <= 1'b0;
        stall_left = 0;
        stall_pct  = 0;
        cycle_no   = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                check_result();
            end
            cycle_no++;
            if (cycle_no % 100 == 0)
            begin
                stall_pct = $urandom_range(0, 2) * 12;
            end
            if (tail_phase)
            begin
                stall_left = 0;
                out_ready  <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // stop when no transfer happens for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("FAIL timestamp_delta_histogram");
        $finish;
    end

    // stimulus, drain and verdict
    initial
    begin : stimulus
        logic [31:0] stamp;
        // model state after reset
        prev_stamp = '0;
        stamp_seen = 1'b0;
        low_water  = MIN_START;
        high_water = MAX_START;
        for (int b = 0; b < NBINS; b++)
        begin
            bin_tally[b] = '0;
        end
        fail_count = 0;
        tail_phase = 1'b0;
        gap_pct    = 0;

        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        media_timestamp <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_stamp(directed_stim[i].stamp, directed_stim[i].typed, directed_stim[i].res);
        end

        // random streams: mostly steady spacing, some jitter, resyncs and wraps
        stamp = directed_stim[DIRECTED_ROWS-1].stamp;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
            begin
                gap_pct = $urandom_range(0, 2) * 15;
            end
            if (RANDOM_ITEMS - n <= TAIL_ITEMS)
            begin
                tail_phase = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: stamp = stamp + $urandom_range(0, 2200);
                // right at a bin boundary
                5: stamp = stamp + $urandom_range(1, NBINS) * BIN_W - $urandom_range(0, 1);
                // packet reordering / jitter backward
                6: stamp = stamp - $urandom_range(1, 600);
                // stream resync
                7: stamp = $urandom;
                // huge jump near the signed limits
                8: stamp = stamp + 32'h7fff_0000 + $urandom_range(0, 32'h1_ffff);
                default: stamp = stamp + ($urandom_range(0, 1) ? 32'h8000_0000
                                                               : 32'h7fff_ffff);
            endcase
            send_stamp(stamp, 1'b0, '0);
        end
        in_valid <= 1'b0;

        // wait for every result, then a little longer for strays
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("PASS timestamp_delta_histogram");
        end
        else
        begin
            $display("FAIL timestamp_delta_histogram");
        end
        $finish;
    end

endmodule
